/* rtl/core/assert_macros.svh */
// assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at each rising edge, off while reset is low
`define FMV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// condition at one edge implies expression at the next edge
`define FMV_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

/* rtl/core/fmv_pkg.sv */
// ----------------------------------------------------------------------------
// fmv_pkg
// Types, constants and the CRC-16/CCITT-FALSE byte update for the frame
// validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fmv_pkg;

    typedef enum logic [2:0] {
        ST_VALID   = 3'd0,
        ST_SHORT   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_TYPE    = 3'd3,
        ST_PAYLOAD = 3'd4,
        ST_CRC     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        FLT_NONE  = 2'd0,
        FLT_MAGIC = 2'd2,
        FLT_TYPE  = 2'd3
    } t_fault;

    localparam int unsigned POS_W = 17;

    localparam logic [7:0]       MAGIC_FIRST    = 8'h66;
    localparam logic [7:0]       MAGIC_SECOND   = 8'h75;
    localparam logic [15:0]      CRC_POLY       = 16'h1021;
    localparam logic [15:0]      CRC_INIT       = 16'hFFFF;
    localparam logic [6:0]       MAX_TYPE_RESET = 7'd15;
    localparam logic [POS_W-1:0] HDR_LEN        = 17'd7;
    localparam logic [POS_W-1:0] VERDICT_POS    = 17'd8;
    localparam logic [POS_W-1:0] POS_MAX        = 17'h1FFFF;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/framed_message_validator.sv */
// a result goes from the input register through the frame checks to the result register
// one byte per cycle unless stalled, with combinational crc byte update and frame checks
// the input register stalls only while a result waits under output stall
// reset (i_rst_n low, synchronous) clears the frame state and sets max type to 15
// ----------------------------------------------------------------------------
// framed_message_validator
// Checks byte-serial frames (magic, type, id, length, payload, crc16) and
// gives one verdict per buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module framed_message_validator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [6:0]  i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_of_buffer,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [7:0]       o_message_type,
    output logic [15:0]      o_message_id,
    output logic [15:0]      o_payload_length
);

    localparam int unsigned PW = fmv_pkg::POS_W;

    logic [6:0]     r_max_type;

    logic           r_in_valid;
    logic [7:0]     r_in_byte;
    logic           r_in_last;

    logic [PW-1:0]  r_pos, n_pos;
    logic [15:0]    r_crc, n_crc;
    fmv_pkg::t_fault r_fault, n_fault;
    logic [7:0]     r_type, n_type;
    logic [15:0]    r_id, n_id;
    logic [15:0]    r_len, n_len;
    logic [7:0]     r_crc_hi, n_crc_hi;
    logic           r_done, n_done;

    logic           r_out_valid;
    fmv_pkg::t_status r_status, n_status;
    logic [7:0]     r_out_type;
    logic [15:0]    r_out_id;
    logic [15:0]    r_out_len;

    logic           w_adv;
    logic           w_emit;
    logic [PW-1:0]  w_crc_pos;
    logic [PW-1:0]  w_end_pos;

    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;

    // frame checks on the registered byte
    always_comb begin
        n_fault  = r_fault;
        n_type   = r_type;
        n_id     = r_id;
        n_len    = r_len;
        n_crc    = r_crc;
        n_crc_hi = r_crc_hi;
        n_done   = r_done;
        n_status = fmv_pkg::ST_VALID;
        w_emit   = 1'b0;

        unique case (r_pos)
            17'd0: begin
                if (r_in_byte != fmv_pkg::MAGIC_FIRST) begin
                    n_fault = fmv_pkg::FLT_MAGIC;
                end
            end
            17'd1: begin
                if (r_in_byte != fmv_pkg::MAGIC_SECOND && r_fault == fmv_pkg::FLT_NONE) begin
                    n_fault = fmv_pkg::FLT_MAGIC;
                end
            end
            17'd2: begin
                n_type = r_in_byte;
                if (r_fault == fmv_pkg::FLT_NONE
                        && (r_in_byte[7] || r_in_byte[6:0] > r_max_type)) begin
                    n_fault = fmv_pkg::FLT_TYPE;
                end
            end
            17'd3: n_id = {r_in_byte, 8'h00};
            17'd4: n_id = {r_id[15:8], r_in_byte};
            17'd5: n_len = {r_in_byte, 8'h00};
            17'd6: n_len = {r_len[15:8], r_in_byte};
            default: begin
            end
        endcase

        w_crc_pos = fmv_pkg::HDR_LEN + {1'b0, n_len};
        w_end_pos = w_crc_pos + 17'd1;

        if (r_pos < fmv_pkg::HDR_LEN || r_pos < w_crc_pos) begin
            n_crc = fmv_pkg::crc_byte(r_crc, r_in_byte);
        end else if (r_pos == w_crc_pos) begin
            n_crc_hi = r_in_byte;
        end

        if (r_pos == fmv_pkg::VERDICT_POS && n_fault != fmv_pkg::FLT_NONE) begin
            w_emit   = 1'b1;
            n_status = (n_fault == fmv_pkg::FLT_MAGIC) ? fmv_pkg::ST_MAGIC : fmv_pkg::ST_TYPE;
        end else if (r_pos >= fmv_pkg::VERDICT_POS && r_pos == w_end_pos) begin
            w_emit   = 1'b1;
            n_status = ({r_crc_hi, r_in_byte} == r_crc) ? fmv_pkg::ST_VALID : fmv_pkg::ST_CRC;
        end else if (r_in_last) begin
            w_emit   = 1'b1;
            n_status = (r_pos < fmv_pkg::VERDICT_POS) ? fmv_pkg::ST_SHORT : fmv_pkg::ST_PAYLOAD;
        end

        if (r_done) begin
            w_emit   = 1'b0;
            n_fault  = r_fault;
            n_type   = r_type;
            n_id     = r_id;
            n_len    = r_len;
            n_crc    = r_crc;
            n_crc_hi = r_crc_hi;
        end else if (w_emit) begin
            n_done = 1'b1;
        end

        n_pos = (r_pos == fmv_pkg::POS_MAX) ? r_pos : r_pos + 17'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_type <= fmv_pkg::MAX_TYPE_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_type <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_of_buffer;
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= fmv_pkg::CRC_INIT;
            r_fault  <= fmv_pkg::FLT_NONE;
            r_type   <= '0;
            r_id     <= '0;
            r_len    <= '0;
            r_crc_hi <= '0;
            r_done   <= 1'b0;
        end else if (w_adv) begin
            if (r_in_last) begin
                r_pos    <= '0;
                r_crc    <= fmv_pkg::CRC_INIT;
                r_fault  <= fmv_pkg::FLT_NONE;
                r_type   <= '0;
                r_id     <= '0;
                r_len    <= '0;
                r_crc_hi <= '0;
                r_done   <= 1'b0;
            end else begin
                r_pos    <= n_pos;
                r_crc    <= n_crc;
                r_fault  <= n_fault;
                r_type   <= n_type;
                r_id     <= n_id;
                r_len    <= n_len;
                r_crc_hi <= n_crc_hi;
                r_done   <= n_done;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv && w_emit) begin
            r_status   <= n_status;
            r_out_type <= n_type;
            r_out_id   <= n_id;
            r_out_len  <= n_len;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_message_type   = r_out_type;
    assign o_message_id     = r_out_id;
    assign o_payload_length = r_out_len;

endmodule

`default_nettype wire

/* rtl/core/fmv_checker.sv */
// ----------------------------------------------------------------------------
// fmv_checker
// Port-level checks on the frame validator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fmv_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [2:0]  o_status,
    input wire logic [7:0]  o_message_type,
    input wire logic [15:0] o_message_id,
    input wire logic [15:0] o_payload_length
);

    logic        w_out_wait;
    logic [42:0] w_result;

    assign w_out_wait = o_out_valid && i_out_stall;
    assign w_result   = {o_status, o_message_type, o_message_id, o_payload_length};

    // result held while the sink stalls
    `FMV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_wait, o_out_valid && $stable(w_result))

    // the input side stalls only behind a stalled result
    `FMV_ASSERT(a_stall_cause, i_clk, i_rst_n, !o_in_stall || w_out_wait)

    // status code within its range
    `FMV_ASSERT(a_status_range, i_clk, i_rst_n, !o_out_valid || o_status <= fmv_pkg::ST_CRC)

    // a good frame never carries a type byte with its top bit set
    `FMV_ASSERT(a_valid_type, i_clk, i_rst_n, !(o_out_valid && o_status == fmv_pkg::ST_VALID) || !o_message_type[7])

endmodule

bind framed_message_validator fmv_checker u_fmv_checker (.*);

`default_nettype wire
